### hw/rtl/av_sync_sample_count_corrector_top_defines.svh
// Assertion helpers shared by the corrector RTL.
`ifndef AV_SYNC_SAMPLE_COUNT_CORRECTOR_TOP_DEFINES_SVH
`define AV_SYNC_SAMPLE_COUNT_CORRECTOR_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define ACSC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define ACSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/acsc_pkg.sv
`timescale 1ns / 1ps

package acsc_pkg;

  // field widths
  localparam int DIFF_W     = 25;
  localparam int FRAME_W    = 14;
  localparam int WANT_W     = 15;
  localparam int ACC_W      = 32;
  localparam int COEF_W     = 16;
  localparam int THR_W      = 24;
  localparam int RATE_W     = 18;
  localparam int IN_TDATA_W = 40;
  localparam int OUT_TDATA_W = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // serial multiplier operand widths
  localparam int MUL_B_W = 18;
  localparam int PROD_W  = ACC_W + MUL_B_W;

  // fixed point
  localparam int FRAC_SH    = 16;
  localparam int SEC_SH     = 20;
  localparam int ROUND_HALF = 32768;
  localparam int COEF_ONE   = 65536;
  localparam int PCT_BASE   = 100;

  // parameter defaults
  localparam int AVG_MEASURES_DEF = 20;
  localparam int CORR_PCT_DEF     = 10;

  // register reset values
  localparam logic              SYNC_EN_RST = 1'b1;
  localparam logic [COEF_W-1:0] COEF_RST    = 16'd52057;
  localparam logic [THR_W-1:0]  THR_RST     = 24'd41943;
  localparam logic [THR_W-1:0]  LIMIT_RST   = 24'd10485760;
  localparam logic [RATE_W-1:0] RATE_RST    = 18'd48000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SYNC_ENABLE = 3'd0,
    CFG_AVG_COEF    = 3'd1,
    CFG_DIFF_THR    = 3'd2,
    CFG_NOSYNC_LIM  = 3'd3,
    CFG_SOURCE_RATE = 3'd4
  } acsc_cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_AVG,
    ST_NEG,
    ST_ACC,
    ST_THR_LD,
    ST_MUL_THR,
    ST_CMP,
    ST_FINISH
  } acsc_state_t;

endpackage

### hw/rtl/acsc_sermul.sv
`timescale 1ns / 1ps

// Bit-serial shift-add multiplier, unsigned, one bit of b per cycle.
module acsc_sermul #(
  parameter int A_W = 32,
  parameter int B_W = 18
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic               busy,
  output logic               done,
  output logic [A_W+B_W-1:0] prod
);

  localparam int CNT_W = $clog2(B_W + 1);

  logic [A_W-1:0]     a_r;
  logic [A_W+B_W-1:0] p_r;
  logic [A_W+B_W-1:0] p_nxt;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r;
  logic               done_r;
  logic [A_W:0]       sum;

  // high half accumulates, low half holds the multiplier bits still to go
  assign sum   = {1'b0, p_r[A_W+B_W-1:B_W]} + (p_r[0] ? {1'b0, a_r} : {(A_W+1){1'b0}});
  assign p_nxt = {sum, p_r[B_W-1:1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(B_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      p_r <= {{A_W{1'b0}}, b};
    end else if (busy_r) begin
      p_r <= p_nxt;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign prod = p_r;

endmodule

### hw/rtl/acsc_cdiv.sv
`timescale 1ns / 1ps

// Restoring divider by a constant, one quotient bit per cycle.
module acsc_cdiv #(
  parameter int N_W     = 22,
  parameter int DIVISOR = 100
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [N_W-1:0] num,
  output logic           busy,
  output logic [N_W-1:0] quot
);

  localparam int R_W   = $clog2(DIVISOR + 1);
  localparam int CNT_W = $clog2(N_W + 1);

  logic [R_W-1:0]   rem_r;
  logic [N_W-1:0]   q_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic [R_W:0]     trial;
  logic             ge;

  assign trial = {rem_r, q_r[N_W-1]};
  assign ge    = (trial >= (R_W+1)'(DIVISOR));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(N_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // numerator bits shift out at the top, quotient bits shift in at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r   <= num;
    end else if (busy_r) begin
      rem_r <= ge ? R_W'(trial - (R_W+1)'(DIVISOR)) : R_W'(trial);
      q_r   <= {q_r[N_W-2:0], ge};
    end
  end

  assign busy = busy_r;
  assign quot = q_r;

endmodule

### hw/rtl/av_sync_sample_count_corrector_top.sv
// Audio/video sync sample count corrector. One input word per decoded audio frame carries
// the audio-minus-master clock difference (signed seconds, Q20), a valid flag on in_tuser
// and the frame's sample count; one output word returns the sample count to produce, with
// out_tuser set when the correction was applied. The block keeps an exponentially weighted
// accumulator of the difference and a measurement count, moved only while sync is enabled;
// an invalid difference, or one at or beyond nosync_limit, clears both. After AVG_MEASURES
// measurements, once the averaged difference reaches diff_threshold, the count moves by
// diff * source_rate samples, clipped to within CORRECTION_PERCENT percent of the frame
// count. Between accepted words the shared bit-serial multiplier runs twice in sequence,
// first for the averaging product, then for the threshold product. The result waits in
// an output register, so a new word is taken while it is pending. Configuration is
// written through cfg_valid/cfg_index/cfg_data (always ready); the user must write it
// only while the block is idle, as the block itself does not enforce this.
`timescale 1ns / 1ps
`include "av_sync_sample_count_corrector_top_defines.svh"

module av_sync_sample_count_corrector_top
  import acsc_pkg::*;
#(
  parameter int AVG_MEASURES       = AVG_MEASURES_DEF,
  parameter int CORRECTION_PERCENT = CORR_PCT_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // in_tdata: [24:0] clock_diff, [38:25] frame_samples, [39] zero
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: [0] diff_valid
  input  logic                   in_tuser,
  // out_tdata: [14:0] wanted_samples, [15] zero
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // out_tuser: [0] corrected
  output logic                   out_tuser,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int MC_W    = $clog2(AVG_MEASURES + 1);
  localparam int MULT_W  = $clog2(PCT_BASE + CORRECTION_PERCENT + 1);
  localparam int NUM_W   = FRAME_W + MULT_W;
  localparam int LO_MULT = PCT_BASE - CORRECTION_PERCENT;
  localparam int HI_MULT = PCT_BASE + CORRECTION_PERCENT;
  localparam int P2_W    = DIFF_W + RATE_W;
  localparam int SHIFT_W = P2_W - SEC_SH;
  localparam int WS_W    = SHIFT_W + 2;

  // ---------------------------------------------------------------- config regs
  logic              sync_en_r;
  logic [COEF_W-1:0] coef_r;
  logic [THR_W-1:0]  thr_r;
  logic [THR_W-1:0]  limit_r;
  logic [RATE_W-1:0] rate_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_en_r <= SYNC_EN_RST;
      coef_r    <= COEF_RST;
      thr_r     <= THR_RST;
      limit_r   <= LIMIT_RST;
      rate_r    <= RATE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SYNC_ENABLE: sync_en_r <= cfg_data[0];
        CFG_AVG_COEF:    coef_r    <= cfg_data[COEF_W-1:0];
        CFG_DIFF_THR:    thr_r     <= cfg_data[THR_W-1:0];
        CFG_NOSYNC_LIM:  limit_r   <= cfg_data[THR_W-1:0];
        CFG_SOURCE_RATE: rate_r    <= cfg_data[RATE_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------- control
  acsc_state_t state_r, state_nxt;

  logic in_acc;
  logic ld_neg, ld_acc, start_thr, ld_cmp, out_load;
  logic fin_go;

  logic m1_busy, m1_done, m2_busy, m2_done, dlo_busy, dhi_busy;

  logic out_valid_r;

  assign in_acc = in_tvalid && in_tready;
  assign fin_go = !m2_busy && !dlo_busy && !dhi_busy && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (in_tvalid) state_nxt = ST_MUL_AVG;
      ST_MUL_AVG: if (m1_done) state_nxt = ST_NEG;
      ST_NEG:     state_nxt = ST_ACC;
      ST_ACC:     state_nxt = ST_THR_LD;
      ST_THR_LD:  state_nxt = ST_MUL_THR;
      ST_MUL_THR: if (m1_done) state_nxt = ST_CMP;
      ST_CMP:     state_nxt = ST_FINISH;
      ST_FINISH:  if (fin_go) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    ld_neg    = 1'b0;
    ld_acc    = 1'b0;
    start_thr = 1'b0;
    ld_cmp    = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE:    in_tready = 1'b1;
      ST_NEG:     ld_neg    = 1'b1;
      ST_ACC:     ld_acc    = 1'b1;
      ST_THR_LD:  start_thr = 1'b1;
      ST_CMP:     ld_cmp    = 1'b1;
      ST_FINISH:  out_load  = fin_go;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------------------------------------------------------- input capture
  logic [DIFF_W-1:0]  diff_in, mag_in;
  logic [FRAME_W-1:0] nb_in;

  logic [DIFF_W-1:0]  diff_r;
  logic [FRAME_W-1:0] nb_r;
  logic               ok_r;

  assign diff_in = in_tdata[DIFF_W-1:0];
  assign nb_in   = in_tdata[DIFF_W +: FRAME_W];
  assign mag_in  = diff_in[DIFF_W-1] ? (~diff_in + 1'b1) : diff_in;

  // ok: difference defined and strictly inside the no-sync window
  always_ff @(posedge clk) begin
    if (in_acc) begin
      diff_r <= diff_in;
      nb_r   <= nb_in;
      ok_r   <= in_tuser && (mag_in < DIFF_W'(limit_r));
    end
  end

  // ---------------------------------------------------------------- shared multiplier
  // pass 1: |acc| * coef      pass 2: |acc_new| * (1.0 - coef)
  logic [ACC_W-1:0]   acc_r;
  logic [ACC_W-1:0]   abs_acc;
  logic [MUL_B_W-1:0] m1_b;
  logic [PROD_W-1:0]  prod1;

  assign abs_acc = acc_r[ACC_W-1] ? (~acc_r + 1'b1) : acc_r;
  assign m1_b    = in_acc ? MUL_B_W'(coef_r)
                          : MUL_B_W'((COEF_W+1)'(COEF_ONE) - (COEF_W+1)'(coef_r));

  acsc_sermul #(
    .A_W (ACC_W),
    .B_W (MUL_B_W)
  ) u_mul_acc (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_acc || start_thr),
    .a     (abs_acc),
    .b     (m1_b),
    .busy  (m1_busy),
    .done  (m1_done),
    .prod  (prod1)
  );

  // sample shift magnitude: |diff| * source_rate, runs alongside pass 1
  logic [P2_W-1:0] prod2;

  acsc_sermul #(
    .A_W (DIFF_W),
    .B_W (RATE_W)
  ) u_mul_shift (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_acc),
    .a     (mag_in),
    .b     (rate_r),
    .busy  (m2_busy),
    .done  (m2_done),
    .prod  (prod2)
  );

  // clip bounds, nb * (100 -/+ pct) / 100
  logic [NUM_W-1:0] lo_q, hi_q;

  acsc_cdiv #(
    .N_W     (NUM_W),
    .DIVISOR (PCT_BASE)
  ) u_div_lo (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_acc),
    .num   (NUM_W'(nb_in) * NUM_W'(LO_MULT)),
    .busy  (dlo_busy),
    .quot  (lo_q)
  );

  acsc_cdiv #(
    .N_W     (NUM_W),
    .DIVISOR (PCT_BASE)
  ) u_div_hi (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_acc),
    .num   (NUM_W'(nb_in) * NUM_W'(HI_MULT)),
    .busy  (dhi_busy),
    .quot  (hi_q)
  );

  // ---------------------------------------------------------------- accumulator update
  logic [PROD_W-1:0]        prod_s_r;
  logic signed [PROD_W-1:0] rnd, shd, dext, accsum;
  logic                     acc_fit;
  logic [ACC_W-1:0]         acc_nxt;
  logic [MC_W-1:0]          cnt_r;
  logic                     avg_r;
  logic                     met_r;

  // signed product, rounded half up, floor shift, plus diff, saturated to 32 bits
  assign rnd     = $signed(prod_s_r) + $signed(PROD_W'(ROUND_HALF));
  assign shd     = rnd >>> FRAC_SH;
  assign dext    = $signed({{(PROD_W-DIFF_W){diff_r[DIFF_W-1]}}, diff_r});
  assign accsum  = shd + dext;
  assign acc_fit = (accsum[PROD_W-1:ACC_W-1] == '0) || (accsum[PROD_W-1:ACC_W-1] == '1);
  assign acc_nxt = acc_fit ? accsum[ACC_W-1:0]
                 : (accsum[PROD_W-1] ? {1'b1, {(ACC_W-1){1'b0}}}
                                     : {1'b0, {(ACC_W-1){1'b1}}});

  always_ff @(posedge clk) begin
    if (ld_neg) begin
      prod_s_r <= acc_r[ACC_W-1] ? (~prod1 + 1'b1) : prod1;
    end
    if (ld_acc) begin
      avg_r <= (cnt_r < MC_W'(AVG_MEASURES));
    end
    if (ld_cmp) begin
      met_r <= (prod1 >= PROD_W'({thr_r, {FRAC_SH{1'b0}}}));
    end
  end

  // filter state only moves while sync is enabled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      cnt_r <= '0;
    end else if (ld_acc && sync_en_r) begin
      if (ok_r) begin
        acc_r <= acc_nxt;
        if (cnt_r < MC_W'(AVG_MEASURES)) begin
          cnt_r <= cnt_r + 1'b1;
        end
      end else begin
        acc_r <= '0;
        cnt_r <= '0;
      end
    end
  end

  // ---------------------------------------------------------------- result
  logic [SHIFT_W-1:0]     shift;
  logic signed [WS_W-1:0] ws, lo_s, hi_s;
  logic [WANT_W-1:0]      clip_val;
  logic                   take;
  logic [WANT_W-1:0]      wanted_nxt;
  logic [WANT_W-1:0]      out_wanted_r;
  logic                   out_corr_r;

  assign shift = prod2[P2_W-1:SEC_SH];
  assign lo_s  = $signed(WS_W'(lo_q));
  assign hi_s  = $signed(WS_W'(hi_q));
  assign ws    = diff_r[DIFF_W-1] ? $signed(WS_W'(nb_r) - WS_W'(shift))
                                  : $signed(WS_W'(nb_r) + WS_W'(shift));

  always_comb begin
    if (ws < lo_s) begin
      clip_val = lo_q[WANT_W-1:0];
    end else if (ws > hi_s) begin
      clip_val = hi_q[WANT_W-1:0];
    end else begin
      clip_val = ws[WANT_W-1:0];
    end
  end

  assign take       = sync_en_r && ok_r && !avg_r && met_r;
  assign wanted_nxt = take ? clip_val : WANT_W'(nb_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_wanted_r <= wanted_nxt;
      out_corr_r   <= take;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_wanted_r);
  assign out_tuser  = out_corr_r;

  // ---------------------------------------------------------------- checks
  `ACSC_ASSERT_SAME(a_cnt_range, clk, rst_n, 1'b1, cnt_r <= MC_W'(AVG_MEASURES), "measure count past limit")
  `ACSC_ASSERT_SAME(a_pass_thru, clk, rst_n, out_load && !take, wanted_nxt == WANT_W'(nb_r), "uncorrected count differs from frame count")
  `ACSC_ASSERT_SAME(a_clip, clk, rst_n, out_load && take, (WANT_W'(lo_q) <= wanted_nxt) && (wanted_nxt <= WANT_W'(hi_q)), "corrected count outside clip window")
  `ACSC_ASSERT_NEXT(a_one_word, clk, rst_n, in_acc, !in_tready && (m1_busy || m2_done || m2_busy), "second word taken while one is in flight")

endmodule
